// ===== hdl/y86_execute_stage_core_macros.svh =====
// assertion macros shared by the execute stage sources
// no dependencies; every macro expects a clk and a rst in scope
`ifndef Y86_EXECUTE_STAGE_CORE_MACROS_SVH
`define Y86_EXECUTE_STAGE_CORE_MACROS_SVH

// same-cycle implication, disabled during reset
`define Y86EX_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define Y86EX_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/y86ex_pkg.sv =====
// shared types, instruction encodings and helper constants for the execute stage
// no dependencies
`timescale 1ns / 1ps

package y86ex_pkg;

  // instruction codes
  localparam logic [3:0] IC_HALT  = 4'd0;
  localparam logic [3:0] IC_NOP   = 4'd1;
  localparam logic [3:0] IC_CMOV  = 4'd2;
  localparam logic [3:0] IC_IRMOV = 4'd3;
  localparam logic [3:0] IC_RMMOV = 4'd4;
  localparam logic [3:0] IC_MRMOV = 4'd5;
  localparam logic [3:0] IC_OPQ   = 4'd6;
  localparam logic [3:0] IC_JXX   = 4'd7;
  localparam logic [3:0] IC_CALL  = 4'd8;
  localparam logic [3:0] IC_RET   = 4'd9;
  localparam logic [3:0] IC_PUSH  = 4'd10;
  localparam logic [3:0] IC_POP   = 4'd11;

  // alu function codes
  localparam logic [3:0] ALU_ADD = 4'd0;
  localparam logic [3:0] ALU_SUB = 4'd1;
  localparam logic [3:0] ALU_AND = 4'd2;
  localparam logic [3:0] ALU_XOR = 4'd3;

  // condition selectors
  localparam logic [3:0] C_YES = 4'd0;
  localparam logic [3:0] C_LE  = 4'd1;
  localparam logic [3:0] C_L   = 4'd2;
  localparam logic [3:0] C_E   = 4'd3;
  localparam logic [3:0] C_NE  = 4'd4;
  localparam logic [3:0] C_GE  = 4'd5;
  localparam logic [3:0] C_G   = 4'd6;

  // status codes
  localparam logic [1:0] ST_OK = 2'd0;

  localparam logic [3:0] REG_NONE = 4'hF;

  localparam int unsigned WORD_W = 64;

  localparam logic [WORD_W-1:0] STACK_DEC = 64'hFFFF_FFFF_FFFF_FFF8;
  localparam logic [WORD_W-1:0] STACK_INC = 64'h0000_0000_0000_0008;

  typedef logic [WORD_W-1:0] word_t;

  typedef struct packed {
    logic of;
    logic sf;
    logic zf;
  } cc_t;

  localparam cc_t CC_CLEAR = '{of: 1'b0, sf: 1'b0, zf: 1'b0};

endpackage

// ===== hdl/y86ex_alu.sv =====
// operand selection and alu with flag generation
// depends on y86ex_pkg
`timescale 1ns / 1ps

module y86ex_alu (
  input  logic [3:0]        icode,
  input  logic [3:0]        ifun,
  input  y86ex_pkg::word_t  val_c,
  input  y86ex_pkg::word_t  val_a,
  input  y86ex_pkg::word_t  val_b,
  output y86ex_pkg::word_t  result,
  output y86ex_pkg::cc_t    cc_new
);
  import y86ex_pkg::*;

  word_t      alu_a;
  word_t      alu_b;
  logic [3:0] alu_op;
  logic       ovf;

  always_comb begin
    case (icode)
      IC_CMOV, IC_OPQ:             alu_a = val_a;
      IC_IRMOV, IC_RMMOV, IC_MRMOV: alu_a = val_c;
      IC_CALL, IC_PUSH:            alu_a = STACK_DEC;
      IC_RET, IC_POP:              alu_a = STACK_INC;
      default:                     alu_a = '0;
    endcase
  end

  always_comb begin
    case (icode)
      IC_RMMOV, IC_MRMOV, IC_OPQ, IC_CALL, IC_PUSH, IC_RET, IC_POP: alu_b = val_b;
      default: alu_b = '0;
    endcase
  end

  assign alu_op = (icode == IC_OPQ) ? ifun : ALU_ADD;

  always_comb begin
    case (alu_op)
      ALU_ADD: begin
        result = alu_b + alu_a;
        ovf    = (alu_a[WORD_W-1] ^ result[WORD_W-1]) & (alu_b[WORD_W-1] ^ result[WORD_W-1]);
      end
      ALU_SUB: begin
        result = alu_b - alu_a;
        ovf    = (alu_b[WORD_W-1] ^ alu_a[WORD_W-1]) & (alu_b[WORD_W-1] ^ result[WORD_W-1]);
      end
      ALU_XOR: begin
        result = alu_a ^ alu_b;
        ovf    = 1'b0;
      end
      default: begin
        // and, also for undefined function codes
        result = alu_a & alu_b;
        ovf    = 1'b0;
      end
    endcase
  end

  assign cc_new.zf = (result == '0);
  assign cc_new.sf = result[WORD_W-1];
  assign cc_new.of = ovf;

endmodule

// ===== hdl/y86ex_cond.sv =====
// jump / conditional move evaluation from the current condition codes
// depends on y86ex_pkg
`timescale 1ns / 1ps

module y86ex_cond (
  input  logic [3:0]     icode,
  input  logic [3:0]     ifun,
  input  y86ex_pkg::cc_t cc,
  output logic           cnd
);
  import y86ex_pkg::*;

  logic lt;
  logic sel;

  assign lt = cc.sf ^ cc.of;

  always_comb begin
    case (ifun)
      C_YES:   sel = 1'b1;
      C_LE:    sel = lt | cc.zf;
      C_L:     sel = lt;
      C_E:     sel = cc.zf;
      C_NE:    sel = ~cc.zf;
      C_GE:    sel = ~lt;
      C_G:     sel = ~lt & ~cc.zf;
      default: sel = 1'b0;
    endcase
  end

  assign cnd = sel & ((icode == IC_JXX) | (icode == IC_CMOV));

endmodule

// ===== hdl/y86_execute_stage_core.sv =====
// y86-64 execute stage: one decoded instruction per transaction on the input
// channel (in_valid / in_stall), one memory-register transaction per input on
// the output channel (out_valid / out_stall), plus the forwarding values.
// flow: input register -> alu, condition check and bubble select -> output
// register. the zf/sf/of flag register sits beside the alu and is written when
// an opq leaves the input register and neither later-stage status shows an
// exception; conditions always see the flags left by the previous instruction.
// the input register and then the output register lie between input acceptance
// and output valid; throughput is one transaction per cycle while out_stall is
// low.
// when out_stall is high with a result held, the input register keeps its item
// and in_stall rises; a free input register still takes one more transaction.
// reset (rst, synchronous, active high) empties both registers and clears the
// flags. depends on y86ex_pkg, y86ex_alu, y86ex_cond and the macro header.
`timescale 1ns / 1ps
`include "y86_execute_stage_core_macros.svh"

module y86_execute_stage_core (
  input  logic                    clk,
  input  logic                    rst,
  // input channel
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [1:0]              exec_status,
  input  logic [3:0]              exec_icode,
  input  logic [3:0]              exec_function,
  input  y86ex_pkg::word_t        const_value,
  input  y86ex_pkg::word_t        operand_a,
  input  y86ex_pkg::word_t        operand_b,
  input  logic [3:0]              dest_e_reg,
  input  logic [3:0]              dest_m_reg,
  input  logic [1:0]              memory_stage_status,
  input  logic [1:0]              writeback_status,
  // output channel
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [1:0]              mem_status,
  output logic [3:0]              mem_icode,
  output logic                    mem_condition,
  output y86ex_pkg::word_t        mem_value_e,
  output y86ex_pkg::word_t        mem_value_a,
  output logic [3:0]              mem_dest_e,
  output logic [3:0]              mem_dest_m,
  output logic                    mem_bubble,
  output logic [3:0]              fwd_dest_e,
  output y86ex_pkg::word_t        fwd_value_e
);
  import y86ex_pkg::*;

  // input register
  logic       s1_valid;
  logic [1:0] s1_status;
  logic [3:0] s1_icode;
  logic [3:0] s1_ifun;
  word_t      s1_val_c;
  word_t      s1_val_a;
  word_t      s1_val_b;
  logic [3:0] s1_dst_e;
  logic [3:0] s1_dst_m;
  logic [1:0] s1_m_stat;
  logic [1:0] s1_w_stat;

  // condition codes
  cc_t flags;

  // combinational results
  word_t      alu_res;
  cc_t        cc_new;
  logic       cnd;
  logic       exc;
  logic [3:0] dst_e_fin;
  logic       flags_we;

  // handshake
  logic out_free;
  logic s1_move;
  logic in_take;

  assign out_free = ~out_valid | ~out_stall;
  assign s1_move  = s1_valid & out_free;
  assign in_stall = s1_valid & ~out_free;
  assign in_take  = in_valid & ~in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_status <= exec_status;
      s1_icode  <= exec_icode;
      s1_ifun   <= exec_function;
      s1_val_c  <= const_value;
      s1_val_a  <= operand_a;
      s1_val_b  <= operand_b;
      s1_dst_e  <= dest_e_reg;
      s1_dst_m  <= dest_m_reg;
      s1_m_stat <= memory_stage_status;
      s1_w_stat <= writeback_status;
    end
  end

  y86ex_alu u_alu (
    .icode  (s1_icode),
    .ifun   (s1_ifun),
    .val_c  (s1_val_c),
    .val_a  (s1_val_a),
    .val_b  (s1_val_b),
    .result (alu_res),
    .cc_new (cc_new)
  );

  y86ex_cond u_cond (
    .icode (s1_icode),
    .ifun  (s1_ifun),
    .cc    (flags),
    .cnd   (cnd)
  );

  // any non-ok status in memory or writeback squashes this instruction
  assign exc       = (s1_m_stat != ST_OK) | (s1_w_stat != ST_OK);
  // a cmov that fails its condition writes nothing
  assign dst_e_fin = ((s1_icode == IC_CMOV) && !cnd) ? REG_NONE : s1_dst_e;
  assign flags_we  = s1_move & (s1_icode == IC_OPQ) & ~exc;

  always_ff @(posedge clk) begin
    if (rst) begin
      flags <= CC_CLEAR;
    end else if (flags_we) begin
      flags <= cc_new;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      mem_bubble  <= exc;
      fwd_dest_e  <= dst_e_fin;
      fwd_value_e <= alu_res;
      if (exc) begin
        // bubble: looks like a nop to the memory stage
        mem_status    <= ST_OK;
        mem_icode     <= IC_NOP;
        mem_condition <= 1'b0;
        mem_value_e   <= '0;
        mem_value_a   <= '0;
        mem_dest_e    <= REG_NONE;
        mem_dest_m    <= REG_NONE;
      end else begin
        mem_status    <= s1_status;
        mem_icode     <= s1_icode;
        mem_condition <= cnd;
        mem_value_e   <= alu_res;
        mem_value_a   <= s1_val_a;
        mem_dest_e    <= dst_e_fin;
        mem_dest_m    <= s1_dst_m;
      end
    end
  end

  // checks
  `Y86EX_ASSERT_NEXT(a_flags_hold, !rst && !flags_we, $stable(flags),
    "condition flags changed without a qualifying opq")
  `Y86EX_ASSERT_NOW(a_stall_back, s1_valid && out_valid && out_stall, in_stall,
    "input accepted into a full, blocked pipeline")
  `Y86EX_ASSERT_NOW(a_bubble_nop, out_valid && mem_bubble,
    mem_icode == IC_NOP && mem_dest_e == REG_NONE && mem_dest_m == REG_NONE,
    "bubble transaction is not a nop")
  `Y86EX_ASSERT_NEXT(a_out_fill, !rst && s1_move, out_valid,
    "input register drained without filling the output register")

endmodule
